/* hw/rtl/ecs_pkg.sv */
// ----------------------------------------------------------------------------
// Cube cross sampler package
// Shared types, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int MAX_FACE_SIZE_DEF = 1024;
  localparam int FRACTION_BITS_DEF = 8;
  localparam logic [10:0] FACE_SIZE_RST = 11'd256;

  localparam int CW = 27;
  localparam int AW = 22;
  localparam int CORDIC_ITERS = 16;
  localparam int DIV_BITS = 16;

  localparam logic signed [AW-1:0] ANG_HALF    = 22'sd524288;
  localparam logic signed [AW-1:0] ANG_QUARTER = 22'sd262144;
  localparam logic signed [16:0]   ONE_Q14     = 17'sd16384;
  localparam logic signed [16:0]   INV_GAIN    = 17'sd39797;

  localparam logic [2:0] FACE_NX = 3'd0;
  localparam logic [2:0] FACE_NY = 3'd1;
  localparam logic [2:0] FACE_PX = 3'd2;
  localparam logic [2:0] FACE_PY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic [2:0] face;
    logic [9:0] col;
    logic [9:0] row;
  } in_req_t;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] src_u_lo;
    logic [10:0] src_v_lo;
    logic [11:0] src_u_hi;
    logic [10:0] src_v_hi;
    logic [7:0]  frac_s;
    logic [7:0]  frac_t;
    logic        in_range;
  } out_req_t;

  function automatic logic signed [AW-1:0] atan_ang(input int k);
    logic signed [AW-1:0] v;
    case (k)
      0:  v = 22'sd131072;
      1:  v = 22'sd77376;
      2:  v = 22'sd40884;
      3:  v = 22'sd20753;
      4:  v = 22'sd10417;
      5:  v = 22'sd5213;
      6:  v = 22'sd2607;
      7:  v = 22'sd1304;
      8:  v = 22'sd652;
      9:  v = 22'sd326;
      10: v = 22'sd163;
      11: v = 22'sd81;
      12: v = 22'sd41;
      13: v = 22'sd20;
      14: v = 22'sd10;
      15: v = 22'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/equirect_to_cube_cross_sampler_top.sv */
// ----------------------------------------------------------------------------
// Equirectangular to cube cross sampler
// Address and weight generator for remapping a panorama into a cube cross.
// ----------------------------------------------------------------------------
// The block accepts one pixel request per cycle unless out_ready stalls it, and
// holds 54 register stages between an accepted request and its result.
// These are the 17-stage divider (input register plus 16 quotient
// stages) that forms the face coordinates, the two 17-stage CORDIC vectoring
// pipelines for azimuth and elevation, and three gain, scaling and clamping
// stages. A result waiting on out_ready stalls the whole pipeline.
module equirect_to_cube_cross_sampler_top #(
  parameter int MAX_FACE_SIZE = ecs_pkg::MAX_FACE_SIZE_DEF,
  parameter int FRACTION_BITS = ecs_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ecs_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output ecs_pkg::out_req_t out_rsp,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata
);

  localparam int FW = $clog2(MAX_FACE_SIZE + 1);
  localparam int PW = FW + 21;
  localparam int QW = PW - 18;
  localparam int UW = FW + 2;
  localparam int CW = ecs_pkg::CW;
  localparam int AW = ecs_pkg::AW;
  localparam int SW1 = 28;
  localparam int SW2 = 42;
  localparam int SW3 = AW + 25;

  logic [10:0]   cfg_r;
  logic [FW-1:0] fc;
  logic          en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ecs_pkg::FACE_SIZE_RST;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_r == 11'd0) begin
      fc = FW'(1);
    end else if (int'(cfg_r) > MAX_FACE_SIZE) begin
      fc = FW'(MAX_FACE_SIZE);
    end else begin
      fc = FW'(cfg_r);
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [9:0]  ic, jc;
  logic [15:0] offx, offy;
  logic [15:0] fc16;
  logic        inr;
  logic [11:0] dx, dy;

  assign fc16 = 16'(fc);
  assign ic   = (int'(in_req.col) < int'(fc)) ? in_req.col : 10'(fc);
  assign jc   = (int'(in_req.row) < int'(fc)) ? in_req.row : 10'(fc);
  assign inr  = (int'(in_req.col) < int'(fc)) && (int'(in_req.row) < int'(fc));

  always_comb begin
    case (in_req.face)
      ecs_pkg::FACE_NX: begin offx = fc16;        offy = 16'(3 * fc16); end
      ecs_pkg::FACE_NY: begin offx = '0;          offy = fc16;          end
      ecs_pkg::FACE_PX: begin offx = fc16;        offy = fc16;          end
      ecs_pkg::FACE_PY: begin offx = fc16 << 1;   offy = fc16;          end
      ecs_pkg::FACE_PZ: begin offx = fc16;        offy = '0;            end
      ecs_pkg::FACE_NZ: begin offx = fc16;        offy = fc16 << 1;     end
      default:          begin offx = '0;          offy = '0;            end
    endcase
  end

  assign dx = 12'(16'(in_req.col) + offx);
  assign dy = 12'(16'(in_req.row) + offy);

  logic          d_vld;
  logic [15:0]   qa, qb;
  logic [SW1-1:0] d_side;

  ecs_div #(.FW(FW), .SW(SW1)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .na_i   ({ic, 15'd0}),
    .nb_i   ({jc, 15'd0}),
    .f_i    (fc),
    .side_i ({in_req.face, dx, dy, inr}),
    .vld_o  (d_vld),
    .qa_o   (qa),
    .qb_o   (qb),
    .side_o (d_side)
  );

  logic [2:0]          d_face;
  logic signed [16:0]  a1, b1, xs, ys, zs;
  logic signed [CW-1:0] x1, y1;

  assign d_face = d_side[27:25];
  assign a1 = $signed({1'b0, qa}) - ecs_pkg::ONE_Q14;
  assign b1 = $signed({1'b0, qb}) - ecs_pkg::ONE_Q14;

  always_comb begin
    case (d_face)
      ecs_pkg::FACE_NX: begin xs = -ecs_pkg::ONE_Q14; ys = a1; zs = b1; end
      ecs_pkg::FACE_NY: begin xs = a1; ys = -ecs_pkg::ONE_Q14; zs = -b1; end
      ecs_pkg::FACE_PX: begin xs = ecs_pkg::ONE_Q14; ys = a1; zs = -b1; end
      ecs_pkg::FACE_PY: begin xs = -a1; ys = ecs_pkg::ONE_Q14; zs = -b1; end
      ecs_pkg::FACE_PZ: begin xs = b1; ys = a1; zs = ecs_pkg::ONE_Q14; end
      ecs_pkg::FACE_NZ: begin xs = -b1; ys = a1; zs = -ecs_pkg::ONE_Q14; end
      default:          begin xs = '0; ys = '0; zs = '0; end
    endcase
  end

  assign x1 = CW'($signed({xs, 8'd0}));
  assign y1 = CW'($signed({ys, 8'd0}));

  logic                 c1_vld;
  logic signed [AW-1:0] theta;
  logic signed [CW-1:0] mag;
  logic [SW2-1:0]       c1_side;

  ecs_cordic #(.SW(SW2)) u_azim (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (d_vld),
    .x_i    (x1),
    .y_i    (y1),
    .side_i ({zs, d_side[24:0]}),
    .vld_o  (c1_vld),
    .ang_o  (theta),
    .mag_o  (mag),
    .side_o (c1_side)
  );

  logic signed [CW+16:0] prod;
  logic                  m_vld_r;
  logic signed [CW-1:0]  r_r, zz_r;
  logic signed [AW-1:0]  th_r;
  logic [24:0]           md_r;

  assign prod = mag * ecs_pkg::INV_GAIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= c1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= CW'(prod >>> 16);
      zz_r <= CW'($signed({c1_side[41:25], 8'd0}));
      th_r <= theta;
      md_r <= c1_side[24:0];
    end
  end

  logic                 c2_vld;
  logic signed [AW-1:0] phi;
  logic signed [CW-1:0] mag2;
  logic [SW3-1:0]       c2_side;
  logic signed [AW-1:0] th2, thc, phc;

  ecs_cordic #(.SW(SW3)) u_elev (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (m_vld_r),
    .x_i    (r_r),
    .y_i    (zz_r),
    .side_i ({th_r, md_r}),
    .vld_o  (c2_vld),
    .ang_o  (phi),
    .mag_o  (mag2),
    .side_o (c2_side)
  );

  assign th2 = c2_side[SW3-1:25];
  assign thc = (th2 > ecs_pkg::ANG_HALF) ? ecs_pkg::ANG_HALF :
               (th2 < -ecs_pkg::ANG_HALF) ? -ecs_pkg::ANG_HALF : th2;
  assign phc = (phi > ecs_pkg::ANG_QUARTER) ? ecs_pkg::ANG_QUARTER :
               (phi < -ecs_pkg::ANG_QUARTER) ? -ecs_pkg::ANG_QUARTER : phi;

  logic          p_vld_r;
  logic [PW-1:0] upos_r, vpos_r;
  logic [24:0]   pd_r;
  logic [20:0]   tu, tv;

  assign tu = 21'(thc + ecs_pkg::ANG_HALF);
  assign tv = 21'(ecs_pkg::ANG_QUARTER - phc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= c2_vld && (mag2 == mag2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      upos_r <= PW'(fc) * PW'(tu);
      vpos_r <= PW'(fc) * PW'(tv);
      pd_r   <= c2_side[24:0];
    end
  end

  logic [UW-1:0] umax, vmax, ulo, vlo, uhi, vhi;
  logic [QW-1:0] uq, vq;
  logic [PW-1:0] su, sv, fu, fv, fmax;
  logic [PW-1:0] fsu, fsv;

  assign umax = UW'({fc, 2'b00}) - UW'(1);
  assign vmax = UW'({fc, 1'b0}) - UW'(1);
  assign uq   = QW'(upos_r >> 18);
  assign vq   = QW'(vpos_r >> 18);
  assign ulo  = (uq > QW'(umax)) ? umax : UW'(uq);
  assign vlo  = (vq > QW'(vmax)) ? vmax : UW'(vq);
  assign uhi  = (ulo == umax) ? umax : ulo + UW'(1);
  assign vhi  = (vlo == vmax) ? vmax : vlo + UW'(1);
  assign su   = upos_r - (PW'(ulo) << 18);
  assign sv   = vpos_r - (PW'(vlo) << 18);
  assign fu   = su >> (18 - FRACTION_BITS);
  assign fv   = sv >> (18 - FRACTION_BITS);
  assign fmax = (PW'(1) << FRACTION_BITS) - PW'(1);
  assign fsu  = (fu > fmax) ? fmax : fu;
  assign fsv  = (fv > fmax) ? fmax : fv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rsp.dest_x   <= pd_r[24:13];
      out_rsp.dest_y   <= pd_r[12:1];
      out_rsp.in_range <= pd_r[0];
      out_rsp.src_u_lo <= 12'(ulo);
      out_rsp.src_u_hi <= 12'(uhi);
      out_rsp.src_v_lo <= 11'(vlo);
      out_rsp.src_v_hi <= 11'(vhi);
      out_rsp.frac_s   <= 8'(fsu);
      out_rsp.frac_t   <= 8'(fsv);
    end
  end

endmodule

/* hw/rtl/ecs_div.sv */
// ----------------------------------------------------------------------------
// Pipelined face coordinate divider
// Two lanes of restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ecs_div #(
  parameter int FW = 11,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [24:0]       na_i,
  input  logic [24:0]       nb_i,
  input  logic [FW-1:0]     f_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [15:0]       qa_o,
  output logic [15:0]       qb_o,
  output logic [SW-1:0]     side_o
);

  localparam int NB = ecs_pkg::DIV_BITS;
  localparam int RW = ((FW + NB - 1 > 25) ? FW + NB - 1 : 25) + 1;

  logic [NB:0]   v_r;
  logic [RW-1:0] ra_r [NB+1];
  logic [RW-1:0] rb_r [NB+1];
  logic [NB-1:0] qa_r [NB+1];
  logic [NB-1:0] qb_r [NB+1];
  logic [SW-1:0] s_r  [NB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NB-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r[0] <= RW'(na_i);
      rb_r[0] <= RW'(nb_i);
      qa_r[0] <= '0;
      qb_r[0] <= '0;
      s_r[0]  <= side_i;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_st
    logic [RW-1:0] d;
    assign d = RW'(f_i) << (NB - 1 - i);
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1] <= s_r[i];
        if (ra_r[i] >= d) begin
          ra_r[i+1] <= ra_r[i] - d;
          qa_r[i+1] <= qa_r[i] | (NB'(1) << (NB - 1 - i));
        end else begin
          ra_r[i+1] <= ra_r[i];
          qa_r[i+1] <= qa_r[i];
        end
        if (rb_r[i] >= d) begin
          rb_r[i+1] <= rb_r[i] - d;
          qb_r[i+1] <= qb_r[i] | (NB'(1) << (NB - 1 - i));
        end else begin
          rb_r[i+1] <= rb_r[i];
          qb_r[i+1] <= qb_r[i];
        end
      end
    end
  end

  assign vld_o  = v_r[NB];
  assign qa_o   = qa_r[NB];
  assign qb_o   = qb_r[NB];
  assign side_o = s_r[NB];

endmodule

/* hw/rtl/ecs_cordic.sv */
// ----------------------------------------------------------------------------
// Pipelined CORDIC vectoring unit
// Quadrant fold followed by one rotation stage per iteration.
// ----------------------------------------------------------------------------
module ecs_cordic #(
  parameter int SW = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_i,
  input  logic signed [ecs_pkg::CW-1:0]   x_i,
  input  logic signed [ecs_pkg::CW-1:0]   y_i,
  input  logic [SW-1:0]                   side_i,
  output logic                            vld_o,
  output logic signed [ecs_pkg::AW-1:0]   ang_o,
  output logic signed [ecs_pkg::CW-1:0]   mag_o,
  output logic [SW-1:0]                   side_o
);

  localparam int W  = ecs_pkg::CW;
  localparam int AW = ecs_pkg::AW;
  localparam int NI = ecs_pkg::CORDIC_ITERS;

  logic [NI:0]          v_r;
  logic signed [W-1:0]  x_r [NI+1];
  logic signed [W-1:0]  y_r [NI+1];
  logic signed [AW-1:0] z_r [NI+1];
  logic                 zr_r [NI+1];
  logic [SW-1:0]        s_r [NI+1];

  logic signed [W-1:0]  x0, y0;
  logic signed [AW-1:0] z0;

  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        z0 = ecs_pkg::ANG_QUARTER;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        z0 = -ecs_pkg::ANG_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NI-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= z0;
      zr_r[0] <= (x_i == 0) && (y_i == 0);
      s_r[0]  <= side_i;
    end
  end

  for (genvar k = 0; k < NI; k++) begin : g_it
    logic signed [W-1:0] dx, dy;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        zr_r[k+1] <= zr_r[k];
        s_r[k+1]  <= s_r[k];
        if (y_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + ecs_pkg::atan_ang(k);
        end else begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - ecs_pkg::atan_ang(k);
        end
      end
    end
  end

  assign vld_o  = v_r[NI];
  assign ang_o  = zr_r[NI] ? '0 : z_r[NI];
  assign mag_o  = zr_r[NI] ? '0 : x_r[NI];
  assign side_o = s_r[NI];

endmodule

/* hw/rtl/ecs_checker.sv */
// ----------------------------------------------------------------------------
// Cube cross sampler port checker
// Checks handshake and result consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module ecs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ecs_pkg::out_req_t out_rsp
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("Result request changed while stalled.");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input taken while the pipeline is stalled.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_upair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.src_u_hi == out_rsp.src_u_lo) ||
                  (out_rsp.src_u_hi == out_rsp.src_u_lo + 12'd1))
    else $error("Source columns are not adjacent.");

  a_vpair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.src_v_hi == out_rsp.src_v_lo) ||
                  (out_rsp.src_v_hi == out_rsp.src_v_lo + 11'd1))
    else $error("Source rows are not adjacent.");

endmodule

bind equirect_to_cube_cross_sampler_top ecs_checker u_ecs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);
